[design/ffa_pkg.sv]
package ffa_pkg;

    localparam int FREE_ENTRIES = 64;
    localparam int LIVE_ENTRIES = 64;
    localparam int ADDR_W       = 32;
    localparam int LEN_W        = 25;
    localparam int OP_W         = 2;
    localparam int FIDX_W       = $clog2(FREE_ENTRIES);
    localparam int FCNT_W       = $clog2(FREE_ENTRIES + 1);
    localparam int LIDX_W       = $clog2(LIVE_ENTRIES);
    localparam int LCNT_W       = $clog2(LIVE_ENTRIES + 1);
    localparam int NEED_W       = LEN_W + 1;
    localparam int GRAIN_BITS   = 3;
    localparam int HDR_BYTES    = 8;
    localparam int MIN_BLOCK    = 16;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_NOFIT   = 3'd1,
        STAT_IGNORED = 3'd2,
        STAT_ZERO    = 3'd3,
        STAT_FULL    = 3'd4
    } stat_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_FS_RD, S_FS_CHK, S_LS_RD, S_LS_CHK,
        S_A_DEC, S_A_BLK, S_A_COMMIT, S_F_PRE, S_F_DEC, S_F_ACT,
        S_SHR_RD, S_SHR_WR, S_INS_WR, S_SHL_RD, S_SHL_WR
    } state_t;

    typedef enum logic [1:0] {K_HOLD, K_CLR, K_INC} kop_t;
    typedef enum logic [2:0] {J_HOLD, J_CNT, J_K, J_INC, J_DEC} jop_t;
    typedef enum logic [1:0] {C_HOLD, C_INC, C_DEC} cop_t;
    typedef enum logic [1:0] {RA_K, RA_JM1, RA_JP1} ra_t;
    typedef enum logic [1:0] {WA_J, WA_K, WA_KM1} wa_t;
    typedef enum logic {WD_Q, WD_W} wd_t;
    typedef enum logic [2:0] {
        DP_NONE, DP_STEP, DP_LHIT, DP_ADEC, DP_ABLK, DP_ACOMMIT, DP_FPRE, DP_FDEC
    } dpop_t;

    typedef struct packed {
        logic  latch;
        kop_t  k_op;
        kop_t  l_op;
        jop_t  j_op;
        cop_t  cnt_op;
        logic  fread;
        ra_t   ra_sel;
        logic  fwrite;
        wa_t   wa_sel;
        wd_t   wd_sel;
        logic  lread;
        dpop_t dp_op;
        logic  finish;
        stat_t stat;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] opc;
        logic zero_req;
        logic free_full;
        logic bad_ptr;
        logic k_end;
        logic fs_cont;
        logic l_end;
        logic l_hit;
        logic live_none;
        logic j_at_k;
        logic shl_end;
        logic whole;
        logic fd_bad;
        logic fd_mp;
        logic fd_mn;
    } sts_t;

endpackage

[design/ffa_ctrl.sv]
module ffa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ffa_pkg::sts_t  sts,
    output ffa_pkg::cmd_t  cmd,
    output logic           busy
);

    ffa_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ffa_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffa_pkg::S_IDLE:
            begin
                if (start)
                    state_next = ffa_pkg::S_DECODE;
            end
            ffa_pkg::S_DECODE:
            begin
                unique case (sts.opc)
                    ffa_pkg::OP_ADD:
                        state_next = (sts.zero_req || sts.free_full) ?
                                     ffa_pkg::S_IDLE : ffa_pkg::S_FS_RD;
                    ffa_pkg::OP_ALLOC:
                        state_next = sts.zero_req ? ffa_pkg::S_IDLE : ffa_pkg::S_FS_RD;
                    ffa_pkg::OP_FREE:
                        state_next = sts.bad_ptr ? ffa_pkg::S_IDLE : ffa_pkg::S_LS_RD;
                    default:
                        state_next = ffa_pkg::S_IDLE;
                endcase
            end
            ffa_pkg::S_FS_RD:
            begin
                if (!sts.k_end)
                    state_next = ffa_pkg::S_FS_CHK;
                else if (sts.opc == ffa_pkg::OP_ADD)
                    state_next = ffa_pkg::S_SHR_RD;
                else if (sts.opc == ffa_pkg::OP_ALLOC)
                    state_next = ffa_pkg::S_IDLE;
                else
                    state_next = ffa_pkg::S_F_PRE;
            end
            ffa_pkg::S_FS_CHK:
            begin
                if (sts.fs_cont)
                    state_next = ffa_pkg::S_FS_RD;
                else if (sts.opc == ffa_pkg::OP_ADD)
                    state_next = ffa_pkg::S_SHR_RD;
                else if (sts.opc == ffa_pkg::OP_ALLOC)
                    state_next = ffa_pkg::S_A_DEC;
                else
                    state_next = ffa_pkg::S_F_PRE;
            end
            ffa_pkg::S_LS_RD:
                state_next = sts.l_end ? ffa_pkg::S_IDLE : ffa_pkg::S_LS_CHK;
            ffa_pkg::S_LS_CHK:
                state_next = sts.l_hit ? ffa_pkg::S_FS_RD : ffa_pkg::S_LS_RD;
            ffa_pkg::S_A_DEC:
                state_next = sts.live_none ? ffa_pkg::S_IDLE : ffa_pkg::S_A_BLK;
            ffa_pkg::S_A_BLK:
                state_next = ffa_pkg::S_A_COMMIT;
            ffa_pkg::S_A_COMMIT:
                state_next = sts.whole ? ffa_pkg::S_SHL_RD : ffa_pkg::S_IDLE;
            ffa_pkg::S_F_PRE:
                state_next = ffa_pkg::S_F_DEC;
            ffa_pkg::S_F_DEC:
                state_next = ffa_pkg::S_F_ACT;
            ffa_pkg::S_F_ACT:
            begin
                if (sts.fd_bad)
                    state_next = ffa_pkg::S_IDLE;
                else if (sts.fd_mp)
                    state_next = sts.fd_mn ? ffa_pkg::S_SHL_RD : ffa_pkg::S_IDLE;
                else if (sts.fd_mn || sts.free_full)
                    state_next = ffa_pkg::S_IDLE;
                else
                    state_next = ffa_pkg::S_SHR_RD;
            end
            ffa_pkg::S_SHR_RD:
                state_next = sts.j_at_k ? ffa_pkg::S_INS_WR : ffa_pkg::S_SHR_WR;
            ffa_pkg::S_SHR_WR:
                state_next = ffa_pkg::S_SHR_RD;
            ffa_pkg::S_INS_WR:
                state_next = ffa_pkg::S_IDLE;
            ffa_pkg::S_SHL_RD:
                state_next = sts.shl_end ? ffa_pkg::S_IDLE : ffa_pkg::S_SHL_WR;
            ffa_pkg::S_SHL_WR:
                state_next = ffa_pkg::S_SHL_RD;
            default:
                state_next = ffa_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd        = '0;
        cmd.k_op   = ffa_pkg::K_HOLD;
        cmd.l_op   = ffa_pkg::K_HOLD;
        cmd.j_op   = ffa_pkg::J_HOLD;
        cmd.cnt_op = ffa_pkg::C_HOLD;
        cmd.ra_sel = ffa_pkg::RA_K;
        cmd.wa_sel = ffa_pkg::WA_K;
        cmd.wd_sel = ffa_pkg::WD_W;
        cmd.dp_op  = ffa_pkg::DP_NONE;
        cmd.stat   = ffa_pkg::STAT_OK;
        unique case (state_reg)
            ffa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    cmd.k_op  = ffa_pkg::K_CLR;
                    cmd.l_op  = ffa_pkg::K_CLR;
                end
            end
            ffa_pkg::S_DECODE:
            begin
                unique case (sts.opc)
                    ffa_pkg::OP_ADD:
                    begin
                        if (sts.zero_req)
                        begin
                            cmd.finish = 1'b1;
                            cmd.stat   = ffa_pkg::STAT_ZERO;
                        end
                        else if (sts.free_full)
                        begin
                            cmd.finish = 1'b1;
                            cmd.stat   = ffa_pkg::STAT_FULL;
                        end
                    end
                    ffa_pkg::OP_ALLOC:
                    begin
                        if (sts.zero_req)
                        begin
                            cmd.finish = 1'b1;
                            cmd.stat   = ffa_pkg::STAT_ZERO;
                        end
                    end
                    ffa_pkg::OP_FREE:
                    begin
                        if (sts.bad_ptr)
                        begin
                            cmd.finish = 1'b1;
                            cmd.stat   = ffa_pkg::STAT_IGNORED;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        cmd.stat   = ffa_pkg::STAT_IGNORED;
                    end
                endcase
            end
            ffa_pkg::S_FS_RD:
            begin
                if (!sts.k_end)
                    cmd.fread = 1'b1;
                else if (sts.opc == ffa_pkg::OP_ADD)
                    cmd.j_op = ffa_pkg::J_CNT;
                else if (sts.opc == ffa_pkg::OP_ALLOC)
                begin
                    cmd.finish = 1'b1;
                    cmd.stat   = ffa_pkg::STAT_NOFIT;
                end
            end
            ffa_pkg::S_FS_CHK:
            begin
                if (sts.fs_cont)
                begin
                    cmd.k_op  = ffa_pkg::K_INC;
                    cmd.dp_op = ffa_pkg::DP_STEP;
                end
                else if (sts.opc == ffa_pkg::OP_ADD)
                    cmd.j_op = ffa_pkg::J_CNT;
            end
            ffa_pkg::S_LS_RD:
            begin
                if (sts.l_end)
                begin
                    cmd.finish = 1'b1;
                    cmd.stat   = ffa_pkg::STAT_IGNORED;
                end
                else
                    cmd.lread = 1'b1;
            end
            ffa_pkg::S_LS_CHK:
            begin
                if (sts.l_hit)
                begin
                    cmd.dp_op = ffa_pkg::DP_LHIT;
                    cmd.k_op  = ffa_pkg::K_CLR;
                end
                else
                    cmd.l_op = ffa_pkg::K_INC;
            end
            ffa_pkg::S_A_DEC:
            begin
                if (sts.live_none)
                begin
                    cmd.finish = 1'b1;
                    cmd.stat   = ffa_pkg::STAT_FULL;
                end
                else
                    cmd.dp_op = ffa_pkg::DP_ADEC;
            end
            ffa_pkg::S_A_BLK:
                cmd.dp_op = ffa_pkg::DP_ABLK;
            ffa_pkg::S_A_COMMIT:
            begin
                cmd.dp_op = ffa_pkg::DP_ACOMMIT;
                if (sts.whole)
                    cmd.j_op = ffa_pkg::J_K;
                else
                begin
                    cmd.fwrite = 1'b1;
                    cmd.finish = 1'b1;
                end
            end
            ffa_pkg::S_F_PRE:
                cmd.dp_op = ffa_pkg::DP_FPRE;
            ffa_pkg::S_F_DEC:
                cmd.dp_op = ffa_pkg::DP_FDEC;
            ffa_pkg::S_F_ACT:
            begin
                if (sts.fd_bad)
                begin
                    cmd.finish = 1'b1;
                    cmd.stat   = ffa_pkg::STAT_IGNORED;
                end
                else if (sts.fd_mp)
                begin
                    cmd.fwrite = 1'b1;
                    cmd.wa_sel = ffa_pkg::WA_KM1;
                    if (sts.fd_mn)
                        cmd.j_op = ffa_pkg::J_K;
                    else
                        cmd.finish = 1'b1;
                end
                else if (sts.fd_mn)
                begin
                    cmd.fwrite = 1'b1;
                    cmd.finish = 1'b1;
                end
                else if (sts.free_full)
                begin
                    cmd.finish = 1'b1;
                    cmd.stat   = ffa_pkg::STAT_FULL;
                end
                else
                    cmd.j_op = ffa_pkg::J_CNT;
            end
            ffa_pkg::S_SHR_RD:
            begin
                if (!sts.j_at_k)
                begin
                    cmd.fread  = 1'b1;
                    cmd.ra_sel = ffa_pkg::RA_JM1;
                end
            end
            ffa_pkg::S_SHR_WR:
            begin
                cmd.fwrite = 1'b1;
                cmd.wa_sel = ffa_pkg::WA_J;
                cmd.wd_sel = ffa_pkg::WD_Q;
                cmd.j_op   = ffa_pkg::J_DEC;
            end
            ffa_pkg::S_INS_WR:
            begin
                cmd.fwrite = 1'b1;
                cmd.cnt_op = ffa_pkg::C_INC;
                cmd.finish = 1'b1;
            end
            ffa_pkg::S_SHL_RD:
            begin
                if (sts.shl_end)
                begin
                    cmd.cnt_op = ffa_pkg::C_DEC;
                    cmd.finish = 1'b1;
                end
                else
                begin
                    cmd.fread  = 1'b1;
                    cmd.ra_sel = ffa_pkg::RA_JP1;
                end
            end
            ffa_pkg::S_SHL_WR:
            begin
                cmd.fwrite = 1'b1;
                cmd.wa_sel = ffa_pkg::WA_J;
                cmd.wd_sel = ffa_pkg::WD_Q;
                cmd.j_op   = ffa_pkg::J_INC;
            end
            default:
            begin
                cmd.finish = 1'b0;
            end
        endcase
    end

endmodule

[design/ffa_dp.sv]
module ffa_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ffa_pkg::cmd_t                     cmd,
    input  logic [ffa_pkg::OP_W-1:0]          op,
    input  logic [ffa_pkg::ADDR_W-1:0]        addr,
    input  logic [ffa_pkg::LEN_W-1:0]         size,
    output ffa_pkg::sts_t                     sts,
    output logic                              done,
    output logic [ffa_pkg::ADDR_W-1:0]        ptr,
    output logic [2:0]                        status
);

    localparam int AW = ffa_pkg::ADDR_W;
    localparam int LW = ffa_pkg::LEN_W;
    localparam int NW = ffa_pkg::NEED_W;
    localparam int FC = ffa_pkg::FCNT_W;
    localparam int FI = ffa_pkg::FIDX_W;
    localparam int LC = ffa_pkg::LCNT_W;
    localparam int LI = ffa_pkg::LIDX_W;

    // free extent table and live block table
    logic [AW-1:0] fbase_mem [ffa_pkg::FREE_ENTRIES];
    logic [LW-1:0] flen_mem  [ffa_pkg::FREE_ENTRIES];
    logic [AW-1:0] lbase_mem [ffa_pkg::LIVE_ENTRIES];
    logic [LW-1:0] llen_mem  [ffa_pkg::LIVE_ENTRIES];

    logic [ffa_pkg::LIVE_ENTRIES-1:0] valid_reg;
    logic [FC-1:0] cnt_reg, k_reg, j_reg;
    logic [LC-1:0] l_reg;
    logic          done_reg, have_prev_reg;

    logic [1:0]     op_reg;
    logic [AW-1:0]  addr_reg, blk_reg, wbase_reg, prev_base_reg, ptr_reg, nb_reg;
    logic [LW-1:0]  size_reg, wlen_reg, blen_reg, prev_len_reg;
    logic [NW-1:0]  need_reg, sumn_reg;
    logic [AW:0]    pend_reg;
    logic [AW-1:0]  fb_q, lb_q;
    logic [LW-1:0]  fl_q, ll_q;
    logic [LI-1:0]  slot_reg;
    logic           whole_reg, fd_bad_reg, fd_mp_reg, fd_mn_reg;
    ffa_pkg::stat_t status_reg;

    logic [NW-1:0]  need_raw, need_calc;
    logic [FC-1:0]  ra_full, wa_full;
    logic [AW-1:0]  wr_base;
    logic [LW-1:0]  wr_len;
    logic [LI-1:0]  free_slot, l_idx;
    logic           live_none, whole_calc, fs_cont;
    logic [NW-1:0]  total;
    logic [NW:0]    psum;
    logic           mn_calc, mp_calc, bad_calc;

    assign l_idx = l_reg[LI-1:0];

    assign need_raw  = (NW'(size) + NW'(ffa_pkg::HDR_BYTES + (1 << ffa_pkg::GRAIN_BITS) - 1))
                       & ~NW'((1 << ffa_pkg::GRAIN_BITS) - 1);
    assign need_calc = (need_raw < NW'(ffa_pkg::MIN_BLOCK)) ? NW'(ffa_pkg::MIN_BLOCK) : need_raw;

    // lowest unused live slot
    always_comb
    begin
        free_slot = '0;
        for (int i = ffa_pkg::LIVE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_slot = LI'(i);
        end
    end
    assign live_none = &valid_reg;

    assign whole_calc = ({2'b00, fl_q} < ({1'b0, need_reg} + (NW+1)'(ffa_pkg::MIN_BLOCK)));

    always_comb
    begin
        case (op_reg)
            ffa_pkg::OP_ADD:   fs_cont = (fb_q < addr_reg);
            ffa_pkg::OP_ALLOC: fs_cont = (NW'(fl_q) < need_reg);
            default:           fs_cont = (fb_q <= blk_reg);
        endcase
    end

    // merge decision for a free
    assign mn_calc  = (k_reg < cnt_reg) && (nb_reg == fb_q) &&
                      (sumn_reg <= NW'(ffa_pkg::LEN_MAX));
    assign total    = mn_calc ? sumn_reg : NW'(blen_reg);
    assign psum     = (NW+1)'(prev_len_reg) + (NW+1)'(total);
    assign mp_calc  = have_prev_reg && (pend_reg[AW-1:0] == blk_reg) &&
                      (psum <= (NW+1)'(ffa_pkg::LEN_MAX));
    assign bad_calc = have_prev_reg && ({1'b0, blk_reg} < pend_reg);

    always_comb
    begin
        case (cmd.ra_sel)
            ffa_pkg::RA_JM1: ra_full = j_reg - FC'(1);
            ffa_pkg::RA_JP1: ra_full = j_reg + FC'(1);
            default:         ra_full = k_reg;
        endcase
        case (cmd.wa_sel)
            ffa_pkg::WA_J:   wa_full = j_reg;
            ffa_pkg::WA_KM1: wa_full = k_reg - FC'(1);
            default:         wa_full = k_reg;
        endcase
        if (cmd.wd_sel == ffa_pkg::WD_Q)
        begin
            wr_base = fb_q;
            wr_len  = fl_q;
        end
        else
        begin
            wr_base = wbase_reg;
            wr_len  = wlen_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fwrite)
        begin
            fbase_mem[wa_full[FI-1:0]] <= wr_base;
            flen_mem[wa_full[FI-1:0]]  <= wr_len;
        end
        if (cmd.fread)
        begin
            fb_q <= fbase_mem[ra_full[FI-1:0]];
            fl_q <= flen_mem[ra_full[FI-1:0]];
        end
        if (cmd.dp_op == ffa_pkg::DP_ACOMMIT)
        begin
            lbase_mem[slot_reg] <= blk_reg;
            llen_mem[slot_reg]  <= blen_reg;
        end
        if (cmd.lread)
        begin
            lb_q <= lbase_mem[l_idx];
            ll_q <= llen_mem[l_idx];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            l_reg         <= '0;
            done_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            case (cmd.k_op)
                ffa_pkg::K_CLR: k_reg <= '0;
                ffa_pkg::K_INC: k_reg <= k_reg + FC'(1);
                default:        k_reg <= k_reg;
            endcase
            case (cmd.l_op)
                ffa_pkg::K_CLR: l_reg <= '0;
                ffa_pkg::K_INC: l_reg <= l_reg + LC'(1);
                default:        l_reg <= l_reg;
            endcase
            case (cmd.j_op)
                ffa_pkg::J_CNT: j_reg <= cnt_reg;
                ffa_pkg::J_K:   j_reg <= k_reg;
                ffa_pkg::J_INC: j_reg <= j_reg + FC'(1);
                ffa_pkg::J_DEC: j_reg <= j_reg - FC'(1);
                default:        j_reg <= j_reg;
            endcase
            case (cmd.cnt_op)
                ffa_pkg::C_INC: cnt_reg <= cnt_reg + FC'(1);
                ffa_pkg::C_DEC: cnt_reg <= cnt_reg - FC'(1);
                default:        cnt_reg <= cnt_reg;
            endcase
            if (cmd.latch)
                have_prev_reg <= 1'b0;
            else if (cmd.dp_op == ffa_pkg::DP_STEP && op_reg == ffa_pkg::OP_FREE)
                have_prev_reg <= 1'b1;
            if (cmd.dp_op == ffa_pkg::DP_ACOMMIT)
                valid_reg[slot_reg] <= 1'b1;
            if (cmd.finish && cmd.stat == ffa_pkg::STAT_OK && op_reg == ffa_pkg::OP_FREE)
                valid_reg[slot_reg] <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= op;
            addr_reg  <= addr;
            size_reg  <= size;
            need_reg  <= need_calc;
            blk_reg   <= addr - AW'(ffa_pkg::HDR_BYTES);
            wbase_reg <= addr;
            wlen_reg  <= size;
        end
        case (cmd.dp_op)
            ffa_pkg::DP_STEP:
            begin
                prev_base_reg <= fb_q;
                prev_len_reg  <= fl_q;
            end
            ffa_pkg::DP_LHIT:
            begin
                slot_reg <= l_idx;
                blen_reg <= ll_q;
            end
            ffa_pkg::DP_ADEC:
            begin
                wbase_reg <= fb_q;
                wlen_reg  <= fl_q - LW'(need_reg);
                blen_reg  <= whole_calc ? fl_q : LW'(need_reg);
                whole_reg <= whole_calc;
                slot_reg  <= free_slot;
            end
            ffa_pkg::DP_ABLK:
                blk_reg <= whole_reg ? wbase_reg : wbase_reg + AW'(wlen_reg);
            ffa_pkg::DP_FPRE:
            begin
                pend_reg <= {1'b0, prev_base_reg} + (AW+1)'(prev_len_reg);
                nb_reg   <= blk_reg + AW'(blen_reg);
                sumn_reg <= NW'(blen_reg) + NW'(fl_q);
            end
            ffa_pkg::DP_FDEC:
            begin
                fd_bad_reg <= bad_calc;
                fd_mp_reg  <= mp_calc;
                fd_mn_reg  <= mn_calc;
                if (mp_calc)
                begin
                    wbase_reg <= prev_base_reg;
                    wlen_reg  <= psum[LW-1:0];
                end
                else
                begin
                    wbase_reg <= blk_reg;
                    wlen_reg  <= mn_calc ? total[LW-1:0] : blen_reg;
                end
            end
            default:
            begin
                whole_reg <= whole_reg;
            end
        endcase
        if (cmd.finish)
        begin
            status_reg <= cmd.stat;
            ptr_reg    <= (cmd.stat == ffa_pkg::STAT_OK && op_reg == ffa_pkg::OP_ALLOC) ?
                          blk_reg + AW'(ffa_pkg::HDR_BYTES) : '0;
        end
    end

    assign sts.opc       = op_reg;
    assign sts.zero_req  = (size_reg == '0);
    assign sts.free_full = (cnt_reg == FC'(ffa_pkg::FREE_ENTRIES));
    assign sts.bad_ptr   = (addr_reg == '0) || (addr_reg[ffa_pkg::GRAIN_BITS-1:0] != '0);
    assign sts.k_end     = (k_reg >= cnt_reg);
    assign sts.fs_cont   = fs_cont;
    assign sts.l_end     = (l_reg == LC'(ffa_pkg::LIVE_ENTRIES));
    assign sts.l_hit     = valid_reg[l_idx] && (lb_q == blk_reg);
    assign sts.live_none = live_none;
    assign sts.j_at_k    = (j_reg == k_reg);
    assign sts.shl_end   = ({1'b0, j_reg} + (FC+1)'(1)) >= {1'b0, cnt_reg};
    assign sts.whole     = whole_reg;
    assign sts.fd_bad    = fd_bad_reg;
    assign sts.fd_mp     = fd_mp_reg;
    assign sts.fd_mn     = fd_mn_reg;

    assign done   = done_reg;
    assign ptr    = ptr_reg;
    assign status = status_reg;

endmodule

[design/first_fit_free_list_allocator_core.sv]
// Address-ordered first-fit allocator.
// Command channel: op, addr, size are taken at a clock edge where start is high
// and busy is low. op 0 adds a free region (addr, size bytes), op 1 allocates
// size bytes, op 2 frees the user pointer on addr.
// Result channel: every transaction yields exactly one result, ptr and status,
// shown for one cycle with done high. The receiver cannot stall; done drops
// the cycle after. busy falls in the cycle done is shown, so a new command may
// be issued alongside a result.
// Commands rejected at decode finish there. Otherwise the free table is walked
// one entry at a time, a read state then a check state (registered table read),
// the live table likewise on a free, and an insert or removal in the free
// table moves one entry at a time, a read state then a write state;
// one command is in flight at a time.
// Reset: the free list is empty and no block is live; table contents are
// not cleared, only the entry count and the live valid bits.
module first_fit_free_list_allocator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ffa_pkg::OP_W-1:0]    op,
    input  logic [ffa_pkg::ADDR_W-1:0]  addr,
    input  logic [ffa_pkg::LEN_W-1:0]   size,
    output logic                        done,
    output logic [ffa_pkg::ADDR_W-1:0]  ptr,
    output logic [2:0]                  status
);

    ffa_pkg::cmd_t cmd;
    ffa_pkg::sts_t sts;

    ffa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    ffa_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .op     (op),
        .addr   (addr),
        .size   (size),
        .sts    (sts),
        .done   (done),
        .ptr    (ptr),
        .status (status)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held two cycles");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while controller busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start work");

    a_ptr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ffa_pkg::STAT_OK) |-> (ptr == '0))
        else $error("nonzero pointer on failed transaction");

endmodule
